>>> hdl/fbpa_pkg.sv
package fbpa_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] req_size;
		logic [31:0] address;
		logic [31:0] guard_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] block_address;
	} rsp_t;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_GUARD = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_NULL      = 3'd2,
		ST_RANGE     = 3'd3,
		ST_REBUILT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		FS_SWEEP,
		FS_IDLE,
		FS_ALLOC,
		FS_MUL,
		FS_IDX,
		FS_GUARD,
		FS_HOLD
	} fsm_t;

	localparam logic [0:0] CFG_POOL_BASE   = 1'd0;
	localparam logic [0:0] CFG_GUARD_VALUE = 1'd1;

	localparam logic [31:0] POOL_BASE_RST = 32'd4096;
	localparam logic [31:0] GUARD_RST     = 32'hDEADBEEF;

endpackage

>>> hdl/fbpa_addr_chk.sv
module fbpa_addr_chk #(
	parameter int BLOCK_COUNT = 64,
	parameter int BLOCK_BYTES = 16
) (
	input  logic                           clk,
	input  logic                           load,
	input  logic [31:0]                    address,
	input  logic [31:0]                    pool_base,
	output fbpa_pkg::status_t              status,
	output logic [$clog2(BLOCK_COUNT)-1:0] idx
);

	localparam int AW     = $clog2(BLOCK_COUNT);
	localparam int OFF_W  = $clog2(BLOCK_COUNT * BLOCK_BYTES);
	localparam int LOG_B  = $clog2(BLOCK_BYTES);
	localparam int SH     = OFF_W + LOG_B;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
	localparam int RW     = $clog2(RECIP + 64'd1);
	localparam int PW     = OFF_W + RW;
	localparam logic [RW-1:0] RECIP_C  = RW'(RECIP);
	localparam logic [31:0]   LAST_OFF = 32'((BLOCK_COUNT - 1) * BLOCK_BYTES);

	logic [31:0]   off_s1;
	logic          null_s1;
	logic [PW-1:0] prod_s2;
	logic [31:0]   off_s2;
	logic          null_s2;
	logic          in_range_s2;
	logic [31:0]   idx_off;

	// offset from block zero
	always_ff @(posedge clk) begin
		if (load) begin
			off_s1  <= address - pool_base;
			null_s1 <= (address == 32'd0);
		end
	end

	// index by reciprocal multiply, exact for offsets inside the pool
	always_ff @(posedge clk) begin
		prod_s2     <= PW'(off_s1[OFF_W-1:0]) * PW'(RECIP_C);
		off_s2      <= off_s1;
		null_s2     <= null_s1;
		in_range_s2 <= (off_s1 <= LAST_OFF);
	end

	assign idx     = prod_s2[SH +: AW];
	assign idx_off = {{(32-AW){1'b0}}, idx} * 32'(BLOCK_BYTES);

	always_comb begin
		if (null_s2) begin
			status = fbpa_pkg::ST_NULL;
		end else if (!in_range_s2 || (off_s2 != idx_off)) begin
			status = fbpa_pkg::ST_RANGE;
		end else begin
			status = fbpa_pkg::ST_OK;
		end
	end

endmodule

>>> hdl/fbpa_core.sv
module fbpa_core #(
	parameter int BLOCK_COUNT = 64,
	parameter int BLOCK_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  fbpa_pkg::req_t   req,
	input  logic [31:0]      pool_base,
	input  logic [31:0]      guard_value,
	output logic             res_valid,
	input  logic             res_ready,
	output fbpa_pkg::rsp_t   res
);

	localparam int AW = $clog2(BLOCK_COUNT);
	localparam int IW = $clog2(BLOCK_COUNT + 1);
	localparam logic [IW-1:0] NIL  = IW'(BLOCK_COUNT);
	localparam logic [AW-1:0] LAST = AW'(BLOCK_COUNT - 1);

	fbpa_pkg::fsm_t    state_q, state_d;
	logic [IW-1:0]     head_q, head_d;
	logic              head_we;
	logic [AW-1:0]     cnt_q;
	logic              rebuild_q;
	logic              rebuild_start;
	logic [31:0]       sweep_word_q;
	fbpa_pkg::req_t    req_q;
	fbpa_pkg::rsp_t    res_q;
	fbpa_pkg::rsp_t    fin_res;
	logic              fin;
	logic [AW-1:0]     idx_q;

	logic [IW-1:0]     link_mem [BLOCK_COUNT];
	logic [31:0]       guard_mem [BLOCK_COUNT];
	logic [IW-1:0]     link_rd_q;
	logic [31:0]       guard_rd_q;

	logic              link_we;
	logic [AW-1:0]     link_wa;
	logic [IW-1:0]     link_wd;
	logic              guard_we;
	logic [AW-1:0]     guard_wa;
	logic [31:0]       guard_wd;
	logic              guard_re;

	logic              accept;
	logic              chk_kind;
	logic              sweep_last;
	logic              guard_ok;
	logic              alloc_fail;
	fbpa_pkg::status_t chk_status;
	logic [AW-1:0]     chk_idx;

	assign req_ready  = (state_q == fbpa_pkg::FS_IDLE);
	assign accept     = req_valid && req_ready;
	assign chk_kind   = (req.req_type == fbpa_pkg::REQ_FREE) ||
		(req.req_type == fbpa_pkg::REQ_GUARD);
	assign sweep_last = (state_q == fbpa_pkg::FS_SWEEP) && (cnt_q == LAST);
	assign guard_ok   = (guard_rd_q == guard_value);
	assign alloc_fail = (head_q == NIL) || (req_q.req_size > 16'(BLOCK_BYTES));

	fbpa_addr_chk #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_addr_chk (
		.clk       (clk),
		.load      (accept),
		.address   (req.address),
		.pool_base (pool_base),
		.status    (chk_status),
		.idx       (chk_idx)
	);

	// link memory
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (accept && (head_q != NIL)) begin
			link_rd_q <= link_mem[head_q[AW-1:0]];
		end
	end

	// guard memory
	always_ff @(posedge clk) begin
		if (guard_we) begin
			guard_mem[guard_wa] <= guard_wd;
		end
		if (guard_re) begin
			guard_rd_q <= guard_mem[chk_idx];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fbpa_pkg::FS_SWEEP: begin
				if (sweep_last) begin
					if (!rebuild_q || res_ready) begin
						state_d = fbpa_pkg::FS_IDLE;
					end else begin
						state_d = fbpa_pkg::FS_HOLD;
					end
				end
			end
			fbpa_pkg::FS_IDLE: begin
				if (accept) begin
					state_d = chk_kind ? fbpa_pkg::FS_MUL : fbpa_pkg::FS_ALLOC;
				end
			end
			fbpa_pkg::FS_ALLOC: begin
				state_d = res_ready ? fbpa_pkg::FS_IDLE : fbpa_pkg::FS_HOLD;
			end
			fbpa_pkg::FS_MUL: begin
				state_d = fbpa_pkg::FS_IDX;
			end
			fbpa_pkg::FS_IDX: begin
				if (fin) begin
					state_d = res_ready ? fbpa_pkg::FS_IDLE : fbpa_pkg::FS_HOLD;
				end else begin
					state_d = fbpa_pkg::FS_GUARD;
				end
			end
			fbpa_pkg::FS_GUARD: begin
				if (fin) begin
					state_d = res_ready ? fbpa_pkg::FS_IDLE : fbpa_pkg::FS_HOLD;
				end else begin
					state_d = fbpa_pkg::FS_SWEEP;
				end
			end
			fbpa_pkg::FS_HOLD: begin
				if (res_ready) begin
					state_d = fbpa_pkg::FS_IDLE;
				end
			end
			default: begin
				state_d = fbpa_pkg::FS_IDLE;
			end
		endcase
	end

	// datapath controls and results
	always_comb begin
		fin                   = 1'b0;
		fin_res.status        = fbpa_pkg::ST_OK;
		fin_res.block_address = 32'd0;
		head_we               = 1'b0;
		head_d                = head_q;
		rebuild_start         = 1'b0;
		link_we               = 1'b0;
		link_wa               = cnt_q;
		link_wd               = IW'(cnt_q) + IW'(1);
		guard_we              = 1'b0;
		guard_wa              = cnt_q;
		guard_wd              = sweep_word_q;
		guard_re              = 1'b0;
		case (state_q)
			fbpa_pkg::FS_SWEEP: begin
				link_we  = 1'b1;
				guard_we = 1'b1;
				if (sweep_last) begin
					head_we = 1'b1;
					head_d  = '0;
					if (rebuild_q) begin
						fin            = 1'b1;
						fin_res.status = fbpa_pkg::ST_REBUILT;
					end
				end
			end
			fbpa_pkg::FS_ALLOC: begin
				fin = 1'b1;
				if (req_q.req_type == fbpa_pkg::REQ_ALLOC) begin
					if (alloc_fail) begin
						fin_res.status = fbpa_pkg::ST_EXHAUSTED;
					end else begin
						fin_res.block_address = pool_base +
							({{(32-IW){1'b0}}, head_q} * 32'(BLOCK_BYTES));
						head_we = 1'b1;
						head_d  = link_rd_q;
					end
				end
			end
			fbpa_pkg::FS_IDX: begin
				fin_res.status = chk_status;
				if (chk_status != fbpa_pkg::ST_OK) begin
					fin = 1'b1;
				end else if (req_q.req_type == fbpa_pkg::REQ_GUARD) begin
					fin      = 1'b1;
					guard_we = 1'b1;
					guard_wa = chk_idx;
					guard_wd = req_q.guard_data;
				end else begin
					guard_re = 1'b1;
				end
			end
			fbpa_pkg::FS_GUARD: begin
				if (guard_ok) begin
					fin     = 1'b1;
					link_we = 1'b1;
					link_wa = idx_q;
					link_wd = head_q;
					head_we = 1'b1;
					head_d  = IW'(idx_q);
				end else begin
					rebuild_start = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid = fin || (state_q == fbpa_pkg::FS_HOLD);
	assign res       = (state_q == fbpa_pkg::FS_HOLD) ? res_q : fin_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fbpa_pkg::FS_SWEEP;
			head_q       <= '0;
			cnt_q        <= '0;
			rebuild_q    <= 1'b0;
			sweep_word_q <= fbpa_pkg::GUARD_RST;
		end else begin
			state_q <= state_d;
			if (head_we) begin
				head_q <= head_d;
			end
			if (state_q == fbpa_pkg::FS_SWEEP) begin
				cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + AW'(1);
			end
			if (rebuild_start) begin
				rebuild_q    <= 1'b1;
				sweep_word_q <= guard_value;
			end else if (sweep_last) begin
				rebuild_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == fbpa_pkg::FS_IDX) begin
			idx_q <= chk_idx;
		end
		if (fin) begin
			res_q <= fin_res;
		end
	end

endmodule

>>> hdl/fixed_block_pool_allocator.sv
// channel   signals                         direction  moves
// req       req_valid, req_ready, req       in         one request item
// rsp       rsp_valid, rsp_ready, rsp       out        one result item per request
// cfg       cfg_we, cfg_index, cfg_wdata    in         register write, no handshake
//
// allocate and unused type: result from the ALLOC state, after the link memory read of the head
// guard write or rejected free: result from the IDX state, after the address check (subtract, multiply)
// free: address check plus the guard memory read, result from the GUARD state
// guard mismatch rebuild sweeps all BLOCK_COUNT entries, one link and guard entry per cycle
// after reset the same sweep runs over all entries before req_ready rises
// a stalled result sits in the output register while the next item is taken
module fixed_block_pool_allocator #(
	parameter int BLOCK_COUNT = 64,
	parameter int BLOCK_BYTES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  fbpa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output fbpa_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [31:0]    cfg_wdata
);

	logic [31:0]    pool_base_q;
	logic [31:0]    guard_value_q;
	logic           rsp_valid_q;
	fbpa_pkg::rsp_t rsp_q;
	logic           res_valid;
	logic           res_ready;
	fbpa_pkg::rsp_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= fbpa_pkg::POOL_BASE_RST;
			guard_value_q <= fbpa_pkg::GUARD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fbpa_pkg::CFG_POOL_BASE:   pool_base_q   <= cfg_wdata;
				fbpa_pkg::CFG_GUARD_VALUE: guard_value_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	fbpa_core #(
		.BLOCK_COUNT (BLOCK_COUNT),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.pool_base   (pool_base_q),
		.guard_value (guard_value_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> hdl/fbpa_checker.sv
module fbpa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input fbpa_pkg::rsp_t rsp
);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req_ready high right after an accepted item");

	// a new result only comes from work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result appeared while the block was idle");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != 3'(fbpa_pkg::ST_OK)) |-> rsp.block_address == 32'd0)
		else $error("failed request returned a nonzero address");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
